@@ design/ctt_pkg.sv @@
// shared types and constants for the circle triangle tessellator
// no dependencies; imported by ctt_sine_rom, ctt_div_pipe, the top level and the testbench files
`default_nettype none

package ctt_pkg;

	typedef logic signed [21:0] coord_t;
	typedef logic [7:0] reg_idx_t;

	localparam reg_idx_t REG_RADIUS   = 8'd0;
	localparam reg_idx_t REG_SEGMENTS = 8'd1;
	localparam reg_idx_t REG_OUTLINE  = 8'd2;
	localparam reg_idx_t REG_WIDTH    = 8'd3;

	localparam logic [9:0]  MIN_SEGMENTS = 10'd3;
	localparam logic [9:0]  MAX_SEGMENTS = 10'd512;
	localparam logic [15:0] MIN_WIDTH    = 16'd3;

	localparam int FRACTION_BITS = 8;
	// squared chord below this is shorter than 0.0001 units
	localparam longint unsigned SHORT_L2 =
		((64'd1 << (2 * FRACTION_BITS)) + 64'd99999999) / 64'd100000000;

	localparam int QUO_W = 17;
	localparam logic [14:0] Q15_MAX = 15'h7fff;
	localparam logic [15:0] QUARTER_TURN = 16'h4000;

endpackage

`default_nettype wire

@@ design/ctt_sine_rom.sv @@
// quarter-wave sine table, unsigned Q0.15, two registered read ports
// table is built at elaboration from a fixed-point Taylor series; uses ctt_pkg
`default_nettype none

module ctt_sine_rom import ctt_pkg::*; #(
	parameter int ENTRIES = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic [$clog2(ENTRIES+1)-1:0]   addr_a,
	input  wire logic [$clog2(ENTRIES+1)-1:0]   addr_b,
	output logic      [14:0]                    data_a,
	output logic      [14:0]                    data_b
);

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;

	// one table entry; the entry past the quarter wave is full scale
	function automatic logic [14:0] rom_entry(int k);
		longint unsigned x, x2, t, s, v;
		if (k >= ENTRIES) begin
			return Q15_MAX;
		end
		x = (64'(k) * HALF_PI_Q30 + 64'(ENTRIES / 2)) / 64'(ENTRIES);
		x2 = (x * x) >> 30;
		t = ONE_Q30;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
		s = (x * t) >> 30;
		v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[14:0];
	endfunction

	logic [14:0] rom_w [0:ENTRIES];

	for (genvar k = 0; k <= ENTRIES; k++) begin : g_tab
		localparam logic [14:0] VAL = rom_entry(k);
		assign rom_w[k] = VAL;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_a <= rom_w[addr_a];
			data_b <= rom_w[addr_b];
		end
	end

endmodule

`default_nettype wire

@@ design/ctt_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per stage, two numerators
// sharing one divisor; side data rides along; uses ctt_pkg
`default_nettype none

module ctt_div_pipe import ctt_pkg::*; #(
	parameter int SIDE_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [47:0]       num_x,
	input  wire logic [47:0]       num_y,
	input  wire logic [31:0]       den,
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_valid,
	output logic [QUO_W-1:0]       quo_x,
	output logic [QUO_W-1:0]       quo_y,
	output logic [SIDE_W-1:0]      out_side
);

	logic              v_s    [0:QUO_W];
	logic [47:0]       rx_s   [0:QUO_W];
	logic [47:0]       ry_s   [0:QUO_W];
	logic [QUO_W-1:0]  qx_s   [0:QUO_W];
	logic [QUO_W-1:0]  qy_s   [0:QUO_W];
	logic [31:0]       d_s    [0:QUO_W];
	logic [SIDE_W-1:0] side_s [0:QUO_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g <= QUO_W; g++) begin
				v_s[g] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int g = 0; g < QUO_W; g++) begin
				v_s[g+1] <= v_s[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0]   <= num_x;
			ry_s[0]   <= num_y;
			qx_s[0]   <= '0;
			qy_s[0]   <= '0;
			d_s[0]    <= den;
			side_s[0] <= in_side;
		end
	end

	for (genvar g = 0; g < QUO_W; g++) begin : g_bit
		localparam int B = QUO_W - 1 - g;
		logic [47:0] dsh;
		logic        gex, gey;
		assign dsh = 48'(d_s[g]) << B;
		assign gex = rx_s[g] >= dsh;
		assign gey = ry_s[g] >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[g+1]   <= gex ? rx_s[g] - dsh : rx_s[g];
				ry_s[g+1]   <= gey ? ry_s[g] - dsh : ry_s[g];
				qx_s[g+1]   <= qx_s[g] | (QUO_W'(gex) << B);
				qy_s[g+1]   <= qy_s[g] | (QUO_W'(gey) << B);
				d_s[g+1]    <= d_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_valid = v_s[QUO_W];
	assign quo_x     = qx_s[QUO_W];
	assign quo_y     = qy_s[QUO_W];
	assign out_side  = side_s[QUO_W];

endmodule

`default_nettype wire

@@ design/circle_triangle_tessellator.sv @@
// circle triangle tessellator: vertices of one rim segment of an origin-centred circle
// output rate is one vertex per cycle while out_ready is high; a request gives three vertices
// in fill mode and six in outline mode, and a request giving no vertex does not stall the pipeline
// reset clears the pipeline and loads the register defaults; a segment_count write
// holds both ready lines low while the segment reciprocal is rebuilt
`default_nettype none

module circle_triangle_tessellator import ctt_pkg::*; #(
	parameter int SINE_TABLE_ENTRIES = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [19:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [8:0]  segment_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [21:0]      vertex_x,
	output logic [21:0]      vertex_y,
	output logic [2:0]       corner_number,
	output logic             last_vertex
);

	localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1);
	localparam int RT_STEPS = 31;

	// geometry carried through the square root stages
	typedef struct packed {
		coord_t             ax, ay, bx, by;
		logic signed [22:0] dx, dy;
		logic               drop;
	} geo_t;

	// side data carried through the divider
	typedef struct packed {
		coord_t ax, ay, bx, by;
		logic   neg_x, neg_y;
		logic   drop;
	} dside_t;

	// ---------------- configuration registers ----------------
	logic [19:0] radius_q;
	logic [9:0]  seg_cnt_q;
	logic        outline_q;
	logic [15:0] width_q;
	// floor(2^32 / segment_count), rebuilt bit-serially after each count write
	logic [31:0] recip_q;
	logic [9:0]  rc_rem_q;
	logic [5:0]  rc_cnt_q;
	logic        busy_q;
	logic [9:0]  seg_new;
	logic [10:0] rc_trial;

	assign cfg_ready = !busy_q;

	always_comb begin
		seg_new = cfg_data[9:0];
		if (seg_new < MIN_SEGMENTS) begin
			seg_new = MIN_SEGMENTS;
		end else if (seg_new > MAX_SEGMENTS) begin
			seg_new = MAX_SEGMENTS;
		end
	end

	// numerator 2^32: the only one bit enters on the first step
	assign rc_trial = {rc_rem_q, (rc_cnt_q == 6'd33)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= 20'd8192;
			seg_cnt_q <= 10'd32;
			outline_q <= 1'b0;
			width_q   <= 16'd512;
			recip_q   <= 32'd1 << 27;
			rc_rem_q  <= '0;
			rc_cnt_q  <= '0;
			busy_q    <= 1'b0;
		end else if (busy_q) begin
			if (rc_trial >= {1'b0, seg_cnt_q}) begin
				rc_rem_q <= 10'(rc_trial - {1'b0, seg_cnt_q});
				recip_q  <= {recip_q[30:0], 1'b1};
			end else begin
				rc_rem_q <= rc_trial[9:0];
				recip_q  <= {recip_q[30:0], 1'b0};
			end
			rc_cnt_q <= rc_cnt_q - 6'd1;
			if (rc_cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RADIUS: begin
					radius_q <= cfg_data;
				end
				REG_SEGMENTS: begin
					seg_cnt_q <= seg_new;
					rc_rem_q  <= '0;
					rc_cnt_q  <= 6'd33;
					busy_q    <= 1'b1;
				end
				REG_OUTLINE: begin
					outline_q <= cfg_data[0];
				end
				REG_WIDTH: begin
					width_q <= (cfg_data[15:0] < MIN_WIDTH) ? MIN_WIDTH : cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	// whole pipeline moves together; it stalls only while the output
	// register still holds vertices of an earlier request
	logic adv;
	logic ex_valid_q, ex_drop_q, ex_outline_q;
	logic [2:0] ex_corner_q;
	logic ex_last;

	assign ex_last  = ex_outline_q ? (ex_corner_q == 3'd5) : (ex_corner_q == 3'd2);
	assign adv      = !ex_valid_q || ex_drop_q || (out_ready && ex_last);
	assign in_ready = adv && !busy_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s12;
	logic rt_v [0:RT_STEPS];
	logic dv_out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s12 <= 1'b0;
			for (int g = 0; g <= RT_STEPS; g++) begin
				rt_v[g] <= 1'b0;
			end
		end else if (adv) begin
			v_s1  <= in_valid && in_ready;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			rt_v[0] <= v_s10;
			for (int g = 0; g < RT_STEPS; g++) begin
				rt_v[g+1] <= rt_v[g];
			end
			v_s12 <= rt_v[RT_STEPS];
		end
	end

	// ---------------- s1: request capture ----------------
	logic [9:0] ka_s1, kb_s1;
	logic       drop_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ka_s1   <= {1'b0, segment_index};
			kb_s1   <= 10'({1'b0, segment_index} + 10'd1);
			drop_s1 <= (radius_q == '0) || ({1'b0, segment_index} >= seg_cnt_q);
		end
	end

	// ---------------- s2..s4: phase = floor(k * 65536 / count) ----------------
	// reciprocal estimate is exact or one low; one compare corrects it
	logic [41:0] pa_s2, pb_s2;
	logic [9:0]  ka_s2, kb_s2, ka_s3, kb_s3;
	logic        drop_s2, drop_s3, drop_s4;
	logic [16:0] ea_s3, eb_s3;
	logic [26:0] ma_s3, mb_s3;
	logic [26:0] ra, rb;
	logic [15:0] pha_s4, phb_s4;

	assign ra = 27'({ka_s3, 16'b0}) - ma_s3;
	assign rb = 27'({kb_s3, 16'b0}) - mb_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s2   <= 42'(ka_s1) * 42'(recip_q);
			pb_s2   <= 42'(kb_s1) * 42'(recip_q);
			ka_s2   <= ka_s1;
			kb_s2   <= kb_s1;
			drop_s2 <= drop_s1;

			ea_s3   <= pa_s2[32:16];
			eb_s3   <= pb_s2[32:16];
			ma_s3   <= 27'(pa_s2[32:16]) * 27'(seg_cnt_q);
			mb_s3   <= 27'(pb_s2[32:16]) * 27'(seg_cnt_q);
			ka_s3   <= ka_s2;
			kb_s3   <= kb_s2;
			drop_s3 <= drop_s2;

			// rim point at the full count wraps to phase zero
			pha_s4  <= (ra >= 27'(seg_cnt_q)) ? 16'(ea_s3 + 17'd1) : ea_s3[15:0];
			phb_s4  <= (rb >= 27'(seg_cnt_q)) ? 16'(eb_s3 + 17'd1) : eb_s3[15:0];
			drop_s4 <= drop_s3;
		end
	end

	// ---------------- s5: table addresses, lanes cos a, sin a, cos b, sin b ----------------
	logic [15:0]   ang [0:3];
	logic [IW-1:0] idx_s5 [0:3];
	logic          neg_s5 [0:3];
	logic          drop_s5;

	assign ang[0] = pha_s4 + QUARTER_TURN;
	assign ang[1] = pha_s4;
	assign ang[2] = phb_s4 + QUARTER_TURN;
	assign ang[3] = phb_s4;

	for (genvar l = 0; l < 4; l++) begin : g_addr
		logic [14:0] arg;
		logic [31:0] scaled;
		// odd quadrants mirror the quarter wave
		assign arg    = ang[l][14] ? 15'(15'd16384 - {1'b0, ang[l][13:0]})
		                           : {1'b0, ang[l][13:0]};
		assign scaled = 32'(arg) * 32'(SINE_TABLE_ENTRIES);
		always_ff @(posedge clk) begin
			if (adv) begin
				idx_s5[l] <= scaled[IW+13:14];
				neg_s5[l] <= ang[l][15];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drop_s5 <= drop_s4;
		end
	end

	// ---------------- s6: table read ----------------
	logic [14:0] sn_s6 [0:3];
	logic        neg_s6 [0:3];
	logic        drop_s6;

	ctt_sine_rom #(.ENTRIES(SINE_TABLE_ENTRIES)) u_rom_a (
		.clk    (clk),
		.en     (adv),
		.addr_a (idx_s5[0]),
		.addr_b (idx_s5[1]),
		.data_a (sn_s6[0]),
		.data_b (sn_s6[1])
	);

	ctt_sine_rom #(.ENTRIES(SINE_TABLE_ENTRIES)) u_rom_b (
		.clk    (clk),
		.en     (adv),
		.addr_a (idx_s5[2]),
		.addr_b (idx_s5[3]),
		.data_a (sn_s6[2]),
		.data_b (sn_s6[3])
	);

	// ---------------- s7, s8: scale by radius, round half away from zero ----------------
	logic [34:0] prod_s7 [0:3];
	logic        neg_s7 [0:3];
	coord_t      crd_s8 [0:3];
	logic        drop_s7, drop_s8;

	for (genvar l = 0; l < 4; l++) begin : g_scale
		logic [35:0] rsum;
		logic [20:0] rmag;
		assign rsum = 36'(prod_s7[l]) + 36'd16384;
		assign rmag = rsum[35:15];
		always_ff @(posedge clk) begin
			if (adv) begin
				neg_s6[l]  <= neg_s5[l];
				prod_s7[l] <= 35'(sn_s6[l]) * 35'(radius_q);
				neg_s7[l]  <= neg_s6[l];
				crd_s8[l]  <= neg_s7[l] ? -22'(rmag) : 22'(rmag);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drop_s6 <= drop_s5;
			drop_s7 <= drop_s6;
			drop_s8 <= drop_s7;
		end
	end

	// ---------------- s9, s10: chord and its squares ----------------
	logic signed [22:0] dx_s9, dy_s9, dx_s10, dy_s10;
	coord_t             ax_s9, ay_s9, bx_s9, by_s9;
	coord_t             ax_s10, ay_s10, bx_s10, by_s10;
	logic signed [45:0] dxx_s10, dyy_s10;
	logic               drop_s9, drop_s10;
	logic [45:0]        l2;

	assign l2 = 46'(dxx_s10) + 46'(dyy_s10);

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s9   <= crd_s8[0];
			ay_s9   <= crd_s8[1];
			bx_s9   <= crd_s8[2];
			by_s9   <= crd_s8[3];
			dx_s9   <= 23'(crd_s8[2]) - 23'(crd_s8[0]);
			dy_s9   <= 23'(crd_s8[3]) - 23'(crd_s8[1]);
			drop_s9 <= drop_s8;

			dxx_s10  <= 46'(dx_s9) * 46'(dx_s9);
			dyy_s10  <= 46'(dy_s9) * 46'(dy_s9);
			dx_s10   <= dx_s9;
			dy_s10   <= dy_s9;
			ax_s10   <= ax_s9;
			ay_s10   <= ay_s9;
			bx_s10   <= bx_s9;
			by_s10   <= by_s9;
			drop_s10 <= drop_s9;
		end
	end

	// ---------------- square root of l2 * 65536, one result bit per stage ----------------
	logic [61:0] rt_rad_s  [0:RT_STEPS];
	logic [33:0] rt_rem_s  [0:RT_STEPS];
	logic [30:0] rt_root_s [0:RT_STEPS];
	geo_t        rt_geo_s  [0:RT_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			rt_rad_s[0]       <= {l2, 16'b0};
			rt_rem_s[0]       <= '0;
			rt_root_s[0]      <= '0;
			rt_geo_s[0].ax    <= ax_s10;
			rt_geo_s[0].ay    <= ay_s10;
			rt_geo_s[0].bx    <= bx_s10;
			rt_geo_s[0].by    <= by_s10;
			rt_geo_s[0].dx    <= dx_s10;
			rt_geo_s[0].dy    <= dy_s10;
			// short chord only matters for outline quads
			rt_geo_s[0].drop  <= drop_s10 || (outline_q && (64'(l2) < SHORT_L2));
		end
	end

	for (genvar g = 0; g < RT_STEPS; g++) begin : g_root
		logic [33:0] remn, trial;
		logic        fit;
		assign remn  = {rt_rem_s[g][31:0], rt_rad_s[g][61:60]};
		assign trial = {1'b0, rt_root_s[g], 2'b01};
		assign fit   = remn >= trial;
		always_ff @(posedge clk) begin
			if (adv) begin
				rt_rad_s[g+1]  <= {rt_rad_s[g][59:0], 2'b00};
				rt_rem_s[g+1]  <= fit ? remn - trial : remn;
				rt_root_s[g+1] <= {rt_root_s[g][29:0], fit};
				rt_geo_s[g+1]  <= rt_geo_s[g];
			end
		end
	end

	// ---------------- s12: normal numerators |d| * width ----------------
	geo_t        geo_rt;
	logic [22:0] adx, ady;
	logic [38:0] mx_s12, my_s12;
	logic [30:0] root_s12;
	dside_t      side_s12;

	assign geo_rt = rt_geo_s[RT_STEPS];
	assign adx = geo_rt.dx[22] ? 23'(-geo_rt.dx) : 23'(geo_rt.dx);
	assign ady = geo_rt.dy[22] ? 23'(-geo_rt.dy) : 23'(geo_rt.dy);

	always_ff @(posedge clk) begin
		if (adv) begin
			// normal is (-dy, dx)
			mx_s12         <= 39'(ady) * 39'(width_q);
			my_s12         <= 39'(adx) * 39'(width_q);
			root_s12       <= rt_root_s[RT_STEPS];
			side_s12.ax    <= geo_rt.ax;
			side_s12.ay    <= geo_rt.ay;
			side_s12.bx    <= geo_rt.bx;
			side_s12.by    <= geo_rt.by;
			side_s12.neg_x <= !geo_rt.dy[22];
			side_s12.neg_y <= geo_rt.dx[22];
			side_s12.drop  <= geo_rt.drop;
		end
	end

	// ---------------- divide: round(num * 128 / s) as floor((2 num + s) / 2 s) ----------------
	logic [47:0]      nx_num, ny_num;
	logic [31:0]      dv_den;
	logic [QUO_W-1:0] qx, qy;
	dside_t           dv_side;

	assign nx_num = {1'b0, mx_s12, 8'b0} + 48'(root_s12);
	assign ny_num = {1'b0, my_s12, 8'b0} + 48'(root_s12);
	assign dv_den = {root_s12, 1'b0};

	ctt_div_pipe #(.SIDE_W($bits(dside_t))) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s12),
		.num_x     (nx_num),
		.num_y     (ny_num),
		.den       (dv_den),
		.in_side   (side_s12),
		.out_valid (dv_out_valid),
		.quo_x     (qx),
		.quo_y     (qy),
		.out_side  (dv_side)
	);

	// ---------------- quad corners and output register ----------------
	coord_t nx, ny;
	coord_t p_x [0:3];
	coord_t p_y [0:3];
	coord_t ex_x_q [0:3];
	coord_t ex_y_q [0:3];

	assign nx = dv_side.neg_x ? -22'(qx) : 22'(qx);
	assign ny = dv_side.neg_y ? -22'(qy) : 22'(qy);

	// fill mode: centre, rim a, rim b; outline: a-n, a+n, b+n, b-n
	always_comb begin
		if (outline_q) begin
			p_x[0] = dv_side.ax - nx;
			p_y[0] = dv_side.ay - ny;
			p_x[1] = dv_side.ax + nx;
			p_y[1] = dv_side.ay + ny;
			p_x[2] = dv_side.bx + nx;
			p_y[2] = dv_side.by + ny;
			p_x[3] = dv_side.bx - nx;
			p_y[3] = dv_side.by - ny;
		end else begin
			p_x[0] = '0;
			p_y[0] = '0;
			p_x[1] = dv_side.ax;
			p_y[1] = dv_side.ay;
			p_x[2] = dv_side.bx;
			p_y[2] = dv_side.by;
			p_x[3] = dv_side.bx;
			p_y[3] = dv_side.by;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ex_valid_q   <= 1'b0;
			ex_drop_q    <= 1'b0;
			ex_outline_q <= 1'b0;
			ex_corner_q  <= '0;
		end else if (adv) begin
			ex_valid_q   <= dv_out_valid;
			ex_drop_q    <= dv_side.drop;
			ex_outline_q <= outline_q;
			ex_corner_q  <= '0;
		end else if (out_ready) begin
			ex_corner_q  <= ex_corner_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				ex_x_q[c] <= p_x[c];
				ex_y_q[c] <= p_y[c];
			end
		end
	end

	// outline corner order: a-n, a+n, b+n, a-n, b+n, b-n
	always_comb begin
		case (ex_corner_q)
			3'd1: begin
				vertex_x = ex_x_q[1];
				vertex_y = ex_y_q[1];
			end
			3'd2, 3'd4: begin
				vertex_x = ex_x_q[2];
				vertex_y = ex_y_q[2];
			end
			3'd5: begin
				vertex_x = ex_x_q[3];
				vertex_y = ex_y_q[3];
			end
			default: begin
				vertex_x = ex_x_q[0];
				vertex_y = ex_y_q[0];
			end
		endcase
	end

	assign out_valid     = ex_valid_q && !ex_drop_q;
	assign corner_number = ex_corner_q;
	assign last_vertex   = ex_last;

endmodule

`default_nettype wire

@@ sim/ctt_checker.sv @@
// vertex predictor and scoreboard for the circle triangle tessellator
// watches the config, request and vertex channels; depends on ctt_pkg
`timescale 1ns / 1ps

module ctt_checker import ctt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [19:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [8:0]  segment_index,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [21:0] vertex_x,
	input  wire logic [21:0] vertex_y,
	input  wire logic [2:0]  corner_number,
	input  wire logic        last_vertex,
	output int               mismatches,
	output int               pending
);

	localparam int ROM_ENTRIES = 1024;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;

	typedef struct packed {
		logic [21:0] x;
		logic [21:0] y;
		logic [2:0]  corner;
		logic        last;
	} vertex_t;

	vertex_t expected_vertices[$];
	logic [15:0] sine_q15[ROM_ENTRIES + 1];

	logic [19:0] radius_q;
	logic [9:0]  seg_count_q;
	logic        outline_q;
	logic [15:0] width_q;

	assign pending = expected_vertices.size();

	initial begin
		longint unsigned x, x2, t, s, v;
		longint unsigned divs[5] = '{110, 72, 42, 20, 6};
		mismatches = 0;
		for (int k = 0; k < ROM_ENTRIES; k++) begin
			x = (k * HALF_PI_Q30 + ROM_ENTRIES / 2) / ROM_ENTRIES;
			x2 = (x * x) >> 30;
			t = ONE_Q30;
			for (int j = 0; j < 5; j++)
				t = ONE_Q30 - ((x2 * t) >> 30) / divs[j];
			s = (x * t) >> 30;
			v = (s * 32767 + (64'd1 << 29)) >> 30;
			if (v > 32767)
				v = 32767;
			sine_q15[k] = v[15:0];
		end
		sine_q15[ROM_ENTRIES] = 16'd32767;
	end

	function automatic longint sine_of(logic [15:0] phase);
		logic [1:0]  quad;
		logic [13:0] low;
		longint unsigned arg, idx;
		longint val;
		quad = phase[15:14];
		low = phase[13:0];
		arg = quad[0] ? (64'd16384 - low) : 64'(low);
		idx = (arg * ROM_ENTRIES) >> 14;
		if (idx > ROM_ENTRIES)
			idx = ROM_ENTRIES;
		val = longint'(sine_q15[idx]);
		return quad[1] ? -val : val;
	endfunction

	function automatic longint to_radius(longint c);
		longint unsigned mag;
		longint r;
		mag = (c < 0 ? -c : c) * longint'(radius_q);
		r = (mag + 16384) >> 15;
		return c < 0 ? -r : r;
	endfunction

	// rim point k, with the full turn wrapping back to phase zero
	function automatic void rim_at(int k, output longint x, output longint y);
		longint unsigned ph;
		ph = ((longint'(k) * 65536) / seg_count_q) & 16'hffff;
		x = to_radius(sine_of(ph[15:0] + QUARTER_TURN));
		y = to_radius(sine_of(ph[15:0]));
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint div_round(longint num, longint unsigned den);
		longint unsigned mag;
		longint r;
		mag = num < 0 ? -num : num;
		r = (2 * mag + den) / (2 * den);
		return num < 0 ? -r : r;
	endfunction

	function automatic void push_vertex(int k, longint x, longint y, logic last);
		vertex_t v;
		v.x = x[21:0];
		v.y = y[21:0];
		v.corner = k[2:0];
		v.last = last;
		expected_vertices = {expected_vertices, v};
	endfunction

	function automatic void predict_segment(logic [8:0] idx);
		longint ax, ay, bx, by, dx, dy, nx, ny;
		longint unsigned l2, s;
		if (radius_q == 0 || idx >= seg_count_q)
			return;
		rim_at(int'(idx), ax, ay);
		rim_at(int'(idx) + 1, bx, by);
		if (!outline_q) begin
			push_vertex(0, 0, 0, 1'b0);
			push_vertex(1, ax, ay, 1'b0);
			push_vertex(2, bx, by, 1'b1);
			return;
		end
		dx = bx - ax;
		dy = by - ay;
		l2 = dx * dx + dy * dy;
		// chord too short to give a normal
		if (l2 < (64'd1 << 32) && l2 * 64'd100000000 < (64'd1 << (2 * FRACTION_BITS)))
			return;
		s = floor_sqrt(l2 << 16);
		if (s == 0)
			return;
		nx = div_round(-dy * longint'(width_q) * 128, s);
		ny = div_round(dx * longint'(width_q) * 128, s);
		push_vertex(0, ax - nx, ay - ny, 1'b0);
		push_vertex(1, ax + nx, ay + ny, 1'b0);
		push_vertex(2, bx + nx, by + ny, 1'b0);
		push_vertex(3, ax - nx, ay - ny, 1'b0);
		push_vertex(4, bx + nx, by + ny, 1'b0);
		push_vertex(5, bx - nx, by - ny, 1'b1);
	endfunction

	// channels are sampled on the falling edge, ahead of the rising edge that moves them
	always @(negedge clk or negedge arst_n) begin
		vertex_t got, want;
		if (!arst_n) begin
			radius_q <= 20'd8192;
			seg_count_q <= 10'd32;
			outline_q <= 1'b0;
			width_q <= 16'd512;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RADIUS: radius_q <= cfg_data;
					REG_SEGMENTS: begin
						if (cfg_data[9:0] < MIN_SEGMENTS)
							seg_count_q <= MIN_SEGMENTS;
						else if (cfg_data[9:0] > MAX_SEGMENTS)
							seg_count_q <= MAX_SEGMENTS;
						else
							seg_count_q <= cfg_data[9:0];
					end
					REG_OUTLINE: outline_q <= cfg_data[0];
					REG_WIDTH: width_q <= (cfg_data[15:0] < MIN_WIDTH) ? MIN_WIDTH
						: cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_segment(segment_index);
			if (out_valid && out_ready) begin
				got = '{vertex_x, vertex_y, corner_number, last_vertex};
				if (expected_vertices.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected vertex x=%0d y=%0d corner=%0d last=%0d",
							$signed(got.x), $signed(got.y), got.corner, got.last);
				end else begin
					want = expected_vertices.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"vertex mismatch exp x=%0d y=%0d c=%0d l=%0d",
								" got x=%0d y=%0d c=%0d l=%0d"},
								$signed(want.x), $signed(want.y), want.corner, want.last,
								$signed(got.x), $signed(got.y), got.corner, got.last);
					end
				end
			end
		end
	end

endmodule

@@ sim/tb_top.sv @@
// top of the circle triangle tessellator testbench: clock, reset, stimulus, verdict
// depends on ctt_pkg, circle_triangle_tessellator and ctt_checker
`timescale 1ns / 1ps

module tb_top;
	import ctt_pkg::*;

	// index past the register map, the write must be dropped
	localparam reg_idx_t REG_UNUSED = 8'd200;
	// pipeline depth is 62; leave margin for requests that give no vertex
	localparam int DRAIN_CYCLES = 90;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [19:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [8:0]  segment_index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [21:0] vertex_x, vertex_y;
	logic [2:0]  corner_number;
	logic        last_vertex;

	int mismatches, pending;
	int send_idle_pct = 13;
	int recv_idle_pct = 71;
	int cycles = 0;
	int seg_now = 32; // clamped segment count, to aim indexes at live segments

	always #1 clk = ~clk;

	circle_triangle_tessellator dut (.*);

	ctt_checker u_checker (.*);

	// receiver back-pressure
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// register write, only issued while the block is drained
	task automatic write_reg(reg_idx_t idx, logic [19:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_SEGMENTS)
			seg_now = (data[9:0] < 3) ? 3 : (data[9:0] > 512) ? 512 : int'(data[9:0]);
		@(posedge clk);
	endtask

	// one segment request, with a random gap ahead of it
	task automatic send_segment(logic [8:0] idx);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		segment_index <= idx;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	// sender holds off until every vertex is back, then lets stragglers clear
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_segment();
		if ($urandom_range(0, 1))
			send_segment(9'($urandom_range(0, 511)));
		else
			send_segment(9'($urandom_range(0, seg_now - 1)));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// defaults: first, last and past-the-end segments
		send_segment(9'd0);
		send_segment(9'd31);
		send_segment(9'd32);
		send_segment(9'd511);
		drain();

		// zero radius gives nothing
		write_reg(REG_RADIUS, 20'd0);
		send_segment(9'd0);
		drain();

		// largest radius, segment count clamped down to the maximum
		write_reg(REG_RADIUS, 20'hfffff);
		write_reg(REG_SEGMENTS, 20'h003ff);
		send_segment(9'd511);
		send_segment(9'd0);
		send_segment(9'd256);
		drain();

		// segment count clamped up to three
		write_reg(REG_SEGMENTS, 20'd0);
		for (int i = 0; i < 4; i++)
			send_segment(9'(i));
		drain();

		// outline with the narrowest and widest lines
		write_reg(REG_OUTLINE, 20'd1);
		write_reg(REG_WIDTH, 20'd0);
		send_segment(9'd0);
		send_segment(9'd2);
		drain();
		write_reg(REG_WIDTH, 20'h0ffff);
		send_segment(9'd1);
		drain();

		// tiny radius over many segments: chords collapse to nothing
		write_reg(REG_RADIUS, 20'd1);
		write_reg(REG_SEGMENTS, 20'd512);
		send_segment(9'd0);
		send_segment(9'd100);
		send_segment(9'd511);
		drain();

		// dropped write must leave the registers alone
		write_reg(REG_UNUSED, 20'hfffff);
		send_segment(9'd128);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 2) begin
				send_idle_pct = 71;
				recv_idle_pct = 13;
			end else if (phase == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case ($urandom_range(0, 3))
				0: write_reg(REG_RADIUS, 20'hfffff);
				1: write_reg(REG_RADIUS, 20'($urandom_range(1, 255)));
				default: write_reg(REG_RADIUS, 20'($urandom_range(0, 20'hfffff)));
			endcase
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_SEGMENTS, 20'($urandom_range(0, 1023)));
			else
				write_reg(REG_SEGMENTS, 20'($urandom_range(3, 64)));
			write_reg(REG_OUTLINE, 20'($urandom_range(0, 1)));
			write_reg(REG_WIDTH, 20'($urandom_range(0, 20'hfffff)));
			repeat (20) random_segment();
			drain();
		end

		if (mismatches == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
